### hw/rtl/modular_exponentiation_top_defines.svh
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define MODEXP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("modexp assertion failed");

// next-cycle implication, checked while out of reset
`define MODEXP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("modexp assertion failed");

`endif

### hw/rtl/modexp_pkg.sv
// shared constants, codes and control types for the modular exponentiation block
`default_nettype none
package modexp_pkg;
   localparam int LIMB_COUNT    = 4;
   localparam int LIMB_WIDTH    = 64;
   localparam int WORD_WIDTH    = LIMB_COUNT * LIMB_WIDTH;
   localparam int EXPONENT_BITS = 256;
   localparam int INDEX_WIDTH   = $clog2(LIMB_COUNT);
   localparam int STEP_WIDTH    = $clog2(WORD_WIDTH);
   localparam int BIT_WIDTH     = $clog2(EXPONENT_BITS);

   localparam logic [LIMB_WIDTH-1:0] MOD_RESET_LIMB_0 = 64'h0000_0000_0002_ff7f;
   localparam logic [LIMB_WIDTH-1:0] MOD_RESET_LIMB_1 = 64'h0;
   localparam logic [LIMB_WIDTH-1:0] MOD_RESET_LIMB_2 = 64'h0;
   localparam logic [LIMB_WIDTH-1:0] MOD_RESET_LIMB_3 = 64'h8000_0000_0000_0000;

   localparam logic [1:0] CMD_LOAD_BASE = 2'd0;
   localparam logic [1:0] CMD_LOAD_EXP  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE   = 2'd2;

   localparam logic [1:0] ASEL_BASE = 2'd0;
   localparam logic [1:0] ASEL_ACC  = 2'd1;
   localparam logic [1:0] ASEL_SQ   = 2'd2;

   typedef struct packed {
      logic                   load_base;
      logic                   load_exp;
      logic                   init;
      logic                   mul_start;
      logic                   mul_step;
      logic                   write_back;
      logic                   wr_acc;
      logic                   b_one;
      logic                   exp_shift;
      logic [1:0]             a_sel;
      logic [INDEX_WIDTH-1:0] limb_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_mod;
      logic exp_bit;
   } dp_status_type;
endpackage
`default_nettype wire

### hw/rtl/modexp_if.sv
// request and result channel interfaces
`default_nettype none
interface modexp_req_if;
   import modexp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             cmd;
   logic [INDEX_WIDTH-1:0] limb_index;
   logic [LIMB_WIDTH-1:0]  limb_value;
   modport source (output valid, cmd, limb_index, limb_value, input ready);
   modport sink (input valid, cmd, limb_index, limb_value, output ready);
endinterface

interface modexp_rsp_if;
   import modexp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [LIMB_WIDTH-1:0]  result_limb;
   logic [INDEX_WIDTH-1:0] result_index;
   logic                   last_limb;
   logic                   modulus_error;
   modport source (output valid, result_limb, result_index, last_limb, modulus_error,
                   input ready);
   modport sink (input valid, result_limb, result_index, last_limb, modulus_error,
                 output ready);
endinterface
`default_nettype wire

### hw/rtl/modexp_datapath.sv
// operand stores, modulus registers and the bit-serial modular multiplier
`default_nettype none
module modexp_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  modexp_pkg::dp_cmd_type                cmd,
   output modexp_pkg::dp_status_type             status,
   input  wire  [modexp_pkg::INDEX_WIDTH-1:0]    limb_index,
   input  wire  [modexp_pkg::LIMB_WIDTH-1:0]     limb_value,
   input  wire                                   csr_write_enable,
   input  wire  [modexp_pkg::INDEX_WIDTH-1:0]    csr_index,
   input  wire  [modexp_pkg::LIMB_WIDTH-1:0]     csr_write_data,
   output logic [modexp_pkg::LIMB_WIDTH-1:0]     result_limb
);
   import modexp_pkg::*;

   logic [LIMB_WIDTH-1:0] base_ff [LIMB_COUNT];
   logic [LIMB_WIDTH-1:0] base_in [LIMB_COUNT];
   logic [LIMB_WIDTH-1:0] exp_ff  [LIMB_COUNT];
   logic [LIMB_WIDTH-1:0] exp_in  [LIMB_COUNT];
   logic [LIMB_WIDTH-1:0] mod_ff  [LIMB_COUNT];
   logic [LIMB_WIDTH-1:0] mod_in  [LIMB_COUNT];

   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] sq_ff, sq_in;
   logic [WORD_WIDTH-1:0] r_ff, r_in;
   logic [WORD_WIDTH-1:0] a_ff, a_in;
   logic [WORD_WIDTH-1:0] e_ff, e_in;

   logic [WORD_WIDTH-1:0] base_word, exp_word, mod_word;
   logic [WORD_WIDTH-1:0] a_src, b_word, addend, r_next;
   logic [WORD_WIDTH+1:0] t_sum;
   logic [WORD_WIDTH+2:0] d_one, d_two;

   always_comb begin
      for (int i = 0; i < LIMB_COUNT; i++) begin
         base_word[i*LIMB_WIDTH +: LIMB_WIDTH] = base_ff[i];
         exp_word[i*LIMB_WIDTH +: LIMB_WIDTH]  = exp_ff[i];
         mod_word[i*LIMB_WIDTH +: LIMB_WIDTH]  = mod_ff[i];
      end
   end

   assign status.zero_mod = (mod_word == '0);
   assign status.exp_bit  = e_ff[0];
   assign result_limb     = acc_ff[cmd.limb_sel*LIMB_WIDTH +: LIMB_WIDTH];

   // one reduction step: 2r + a_bit*b, then at most two subtractions of m
   always_comb begin
      case (cmd.a_sel)
         ASEL_BASE: a_src = base_word;
         ASEL_ACC:  a_src = acc_ff;
         ASEL_SQ:   a_src = sq_ff;
         default:   a_src = '0;
      endcase
      b_word = cmd.b_one ? WORD_WIDTH'(1) : sq_ff;
      addend = a_ff[WORD_WIDTH-1] ? b_word : '0;
      t_sum  = {1'b0, r_ff, 1'b0} + {2'b00, addend};
      d_one  = {1'b0, t_sum} - {3'b000, mod_word};
      d_two  = {1'b0, t_sum} - {2'b00, mod_word, 1'b0};
      if (!d_two[WORD_WIDTH+2]) begin
         r_next = d_two[WORD_WIDTH-1:0];
      end else if (!d_one[WORD_WIDTH+2]) begin
         r_next = d_one[WORD_WIDTH-1:0];
      end else begin
         r_next = t_sum[WORD_WIDTH-1:0];
      end
   end

   always_comb begin
      base_in = base_ff;
      exp_in  = exp_ff;
      mod_in  = mod_ff;
      if (cmd.load_base) begin
         base_in[limb_index] = limb_value;
      end
      if (cmd.load_exp) begin
         exp_in[limb_index] = limb_value;
      end
      if (csr_write_enable) begin
         mod_in[csr_index] = csr_write_data;
      end

      acc_in = acc_ff;
      sq_in  = sq_ff;
      r_in   = r_ff;
      a_in   = a_ff;
      e_in   = e_ff;
      if (cmd.init) begin
         acc_in = status.zero_mod ? '0 : WORD_WIDTH'(1);
         e_in   = exp_word;
      end
      if (cmd.exp_shift) begin
         e_in = e_ff >> 1;
      end
      if (cmd.mul_start) begin
         r_in = '0;
         a_in = a_src;
      end
      if (cmd.mul_step) begin
         r_in = r_next;
         a_in = a_ff << 1;
      end
      if (cmd.write_back) begin
         if (cmd.wr_acc) begin
            acc_in = r_ff;
         end else begin
            sq_in = r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIMB_COUNT; i++) begin
            base_ff[i] <= '0;
            exp_ff[i]  <= '0;
         end
         mod_ff[0] <= MOD_RESET_LIMB_0;
         mod_ff[1] <= MOD_RESET_LIMB_1;
         mod_ff[2] <= MOD_RESET_LIMB_2;
         mod_ff[3] <= MOD_RESET_LIMB_3;
      end else begin
         base_ff <= base_in;
         exp_ff  <= exp_in;
         mod_ff  <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      e_ff   <= e_in;
   end
endmodule
`default_nettype wire

### hw/rtl/modexp_ctrl.sv
// sequencer for loads, square-and-multiply passes and result output
`default_nettype none
module modexp_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire  [1:0]                          req_cmd,
   output logic                                req_ready,
   input  wire                                 rsp_ready,
   output logic                                rsp_valid,
   output logic [modexp_pkg::INDEX_WIDTH-1:0]  rsp_index,
   output logic                                rsp_last,
   output logic                                rsp_error,
   output modexp_pkg::dp_cmd_type              dp_cmd,
   input  modexp_pkg::dp_status_type           dp_status
);
   import modexp_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   localparam logic [1:0] PH_BASE = 2'd0;
   localparam logic [1:0] PH_ACC  = 2'd1;
   localparam logic [1:0] PH_SQ   = 2'd2;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             phase_ff, phase_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [BIT_WIDTH-1:0]   bit_ff, bit_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic                   error_ff, error_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_index = index_ff;
   assign rsp_last  = (index_ff == INDEX_WIDTH'(LIMB_COUNT - 1));
   assign rsp_error = error_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      index_in = index_ff;
      error_in = error_ff;
      dp_cmd          = '0;
      dp_cmd.b_one    = (phase_ff == PH_BASE);
      dp_cmd.wr_acc   = (phase_ff == PH_ACC);
      dp_cmd.limb_sel = index_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD_BASE: dp_cmd.load_base = 1'b1;
                  CMD_LOAD_EXP:  dp_cmd.load_exp = 1'b1;
                  CMD_COMPUTE: begin
                     dp_cmd.init = 1'b1;
                     error_in    = dp_status.zero_mod;
                     index_in    = '0;
                     bit_in      = '0;
                     if (dp_status.zero_mod) begin
                        state_in = S_OUT;
                     end else begin
                        // reduce the base first: base * 1 mod m into the square
                        phase_in         = PH_BASE;
                        dp_cmd.mul_start = 1'b1;
                        dp_cmd.a_sel     = ASEL_BASE;
                        step_in          = '0;
                        state_in         = S_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RUN: begin
            dp_cmd.mul_step = 1'b1;
            step_in         = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(WORD_WIDTH - 1)) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            dp_cmd.write_back = 1'b1;
            if (phase_ff == PH_SQ) begin
               dp_cmd.exp_shift = 1'b1;
               bit_in           = bit_ff + 1'b1;
               state_in = (bit_ff == BIT_WIDTH'(EXPONENT_BITS - 1)) ? S_OUT : S_DECIDE;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            dp_cmd.mul_start = 1'b1;
            step_in          = '0;
            state_in         = S_RUN;
            if (phase_ff != PH_ACC && dp_status.exp_bit) begin
               phase_in     = PH_ACC;
               dp_cmd.a_sel = ASEL_ACC;
            end else begin
               phase_in     = PH_SQ;
               dp_cmd.a_sel = ASEL_SQ;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (index_ff == INDEX_WIDTH'(LIMB_COUNT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  index_in = index_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_BASE;
         step_ff  <= '0;
         bit_ff   <= '0;
         index_ff <= '0;
         error_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         index_ff <= index_in;
         error_ff <= error_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/modular_exponentiation_top.sv
// load requests write one limb each; compute runs one reduction of the base, then a square per
// exponent bit plus a multiply per set bit, each of 256 serial reduction steps and a write
// state, with a decision state between multiplies, on a single shared multiplier,
// then 4 result limbs, one per cycle while the sink is ready; one request at a time
// synchronous active-high reset: stores cleared, modulus back to its default prime
`default_nettype none
module modular_exponentiation_top (
   input  wire                                clock,
   input  wire                                reset,
   modexp_req_if.sink                         req_bus,
   modexp_rsp_if.source                       rsp_bus,
   input  wire                                csr_write_enable,
   input  wire [modexp_pkg::INDEX_WIDTH-1:0]  csr_index,
   input  wire [modexp_pkg::LIMB_WIDTH-1:0]   csr_write_data
);
   import modexp_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_index (rsp_bus.result_index),
      .rsp_last  (rsp_bus.last_limb),
      .rsp_error (rsp_bus.modulus_error),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   modexp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .limb_index       (req_bus.limb_index),
      .limb_value       (req_bus.limb_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .result_limb      (rsp_bus.result_limb)
   );
endmodule
`default_nettype wire

### hw/rtl/modexp_checker.sv
// port-level checks on the modular exponentiation block and their binding
`default_nettype none
`include "modular_exponentiation_top_defines.svh"
module modexp_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [modexp_pkg::LIMB_WIDTH-1:0]   result_limb,
   input wire [modexp_pkg::INDEX_WIDTH-1:0]  result_index,
   input wire                                last_limb,
   input wire                                modulus_error
);
   import modexp_pkg::*;

   `MODEXP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `MODEXP_ASSERT_SAME(a_last_match, rsp_valid,
      last_limb == (result_index == INDEX_WIDTH'(LIMB_COUNT - 1)))
   `MODEXP_ASSERT_SAME(a_error_zero, rsp_valid && modulus_error, result_limb == '0)
   `MODEXP_ASSERT_NEXT(a_index_step, rsp_valid && rsp_ready && !last_limb,
      rsp_valid && result_index == $past(result_index) + 1'b1)
   `MODEXP_ASSERT_SAME(a_no_overlap, rsp_valid, !req_ready)
endmodule

bind modular_exponentiation_top modexp_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .result_limb   (rsp_bus.result_limb),
   .result_index  (rsp_bus.result_index),
   .last_limb     (rsp_bus.last_limb),
   .modulus_error (rsp_bus.modulus_error)
);
`default_nettype wire
